// ----- rtl/core/psmv_pkg.sv -----
package psmv_pkg;

  // sizes of the block
  localparam int VECTOR_DEPTH = 1024;
  localparam int VALUE_BITS   = 32;
  localparam int SUM_BITS     = 48;
  localparam int OUT_BITS     = 48;
  localparam int ROW_BITS     = 10;
  localparam int OP_BITS      = 3;
  localparam int ADDR_BITS    = $clog2(VECTOR_DEPTH);
  localparam int IDX_CMP_BITS = 17;

  // command queue between front and back
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  localparam logic signed [63:0] SUM_MAX_W = (64'sd1 <<< (SUM_BITS - 1)) - 64'sd1;
  localparam logic signed [63:0] SUM_MIN_W = -SUM_MAX_W - 64'sd1;
  localparam logic signed [SUM_BITS-1:0] SUM_MAX = SUM_MAX_W[SUM_BITS-1:0];
  localparam logic signed [SUM_BITS-1:0] SUM_MIN = SUM_MIN_W[SUM_BITS-1:0];

  typedef enum logic [OP_BITS-1:0] {
    OP_WRITE   = 3'd0,
    OP_SCALE   = 3'd1,
    OP_COLUMN  = 3'd2,
    OP_END_ROW = 3'd3,
    OP_READ    = 3'd4
  } op_e;

  typedef enum logic {
    KIND_ROW_SUM = 1'b0,
    KIND_READ    = 1'b1
  } kind_e;

  // value with its saturation flag, also the memory word
  typedef struct packed {
    logic                       sat;
    logic signed [SUM_BITS-1:0] value;
  } word_t;

  // classified item handed from front to back
  typedef struct packed {
    op_e                  op;
    logic [ROW_BITS-1:0]  index;
    logic [ADDR_BITS-1:0] addr;
    logic                 in_range;
    word_t                data;
  } cmd_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } queue_status_t;

  // sign-extend an input value and clamp it into the sum range
  function automatic word_t clamp_value(logic signed [VALUE_BITS-1:0] v);
    logic signed [63:0] w;
    word_t              r;
    w = 64'(v);
    r.sat = 1'b0;
    if (w > SUM_MAX_W) begin
      r.value = SUM_MAX;
      r.sat   = 1'b1;
    end else if (w < SUM_MIN_W) begin
      r.value = SUM_MIN;
      r.sat   = 1'b1;
    end else begin
      r.value = w[SUM_BITS-1:0];
    end
    return r;
  endfunction

  // saturating add of two sum-range values
  function automatic word_t sat_add(logic signed [SUM_BITS-1:0] a,
                                    logic signed [SUM_BITS-1:0] b);
    logic [SUM_BITS:0] s;
    word_t             r;
    s = {a[SUM_BITS-1], a} + {b[SUM_BITS-1], b};
    r.sat = s[SUM_BITS] ^ s[SUM_BITS-1];
    if (r.sat) begin
      r.value = s[SUM_BITS] ? SUM_MIN : SUM_MAX;
    end else begin
      r.value = s[SUM_BITS-1:0];
    end
    return r;
  endfunction

  // low output bits of a sum, sign-extended first
  function automatic logic signed [OUT_BITS-1:0] to_out(logic signed [SUM_BITS-1:0] v);
    logic signed [63:0] w;
    w = 64'(v);
    return w[OUT_BITS-1:0];
  endfunction

endpackage

// ----- rtl/core/psmv_in_if.sv -----
interface psmv_in_if;
  logic                                    valid;
  logic                                    ready;
  logic [psmv_pkg::OP_BITS-1:0]            operation;
  logic [psmv_pkg::ROW_BITS-1:0]           index;
  logic signed [psmv_pkg::VALUE_BITS-1:0]  value;

  modport source (output valid, operation, index, value, input ready);
  modport sink (input valid, operation, index, value, output ready);
endinterface

// ----- rtl/core/psmv_out_if.sv -----
interface psmv_out_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  kind;
  logic [psmv_pkg::ROW_BITS-1:0]         row_number;
  logic signed [psmv_pkg::OUT_BITS-1:0]  result_value;
  logic                                  saturated;

  modport source (output valid, kind, row_number, result_value, saturated, input ready);
  modport sink (input valid, kind, row_number, result_value, saturated, output ready);
endinterface

// ----- rtl/core/psmv_cfg_if.sv -----
interface psmv_cfg_if;
  logic valid;
  logic ready;
  logic transpose_mode;

  modport source (output valid, transpose_mode, input ready);
  modport sink (input valid, transpose_mode, output ready);
endinterface

// ----- rtl/core/psmv_front.sv -----
module psmv_front (
  psmv_in_if.sink                in_i,
  input  psmv_pkg::queue_status_t q_status_i,
  output logic                   push_o,
  output psmv_pkg::cmd_t         cmd_o
);

  logic [psmv_pkg::IDX_CMP_BITS-1:0] idx_wide;

  assign in_i.ready = !q_status_i.full;
  assign idx_wide   = psmv_pkg::IDX_CMP_BITS'(in_i.index);

  always_comb begin
    cmd_o.op       = psmv_pkg::op_e'(in_i.operation);
    cmd_o.index    = in_i.index;
    cmd_o.addr     = psmv_pkg::ADDR_BITS'(in_i.index);
    cmd_o.in_range = idx_wide < psmv_pkg::IDX_CMP_BITS'(psmv_pkg::VECTOR_DEPTH);
    cmd_o.data     = psmv_pkg::clamp_value(in_i.value);
    push_o         = 1'b0;
    case (psmv_pkg::op_e'(in_i.operation))
      psmv_pkg::OP_WRITE,
      psmv_pkg::OP_SCALE,
      psmv_pkg::OP_COLUMN,
      psmv_pkg::OP_END_ROW,
      psmv_pkg::OP_READ: push_o = in_i.valid && !q_status_i.full;
      // unknown codes are dropped here
      default: push_o = 1'b0;
    endcase
  end

endmodule

// ----- rtl/core/psmv_queue.sv -----
module psmv_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  psmv_pkg::cmd_t          cmd_i,
  input  logic                    pop_i,
  output psmv_pkg::cmd_t          head_o,
  output psmv_pkg::queue_status_t status_o
);

  psmv_pkg::cmd_t                  slots_q [psmv_pkg::QUEUE_DEPTH];
  logic [psmv_pkg::QPTR_BITS-1:0]  wr_ptr_q, wr_ptr_d;
  logic [psmv_pkg::QPTR_BITS-1:0]  rd_ptr_q, rd_ptr_d;
  logic [psmv_pkg::QCNT_BITS-1:0]  count_q, count_d;

  assign status_o.not_empty = count_q != '0;
  assign status_o.full      = count_q == psmv_pkg::QCNT_BITS'(psmv_pkg::QUEUE_DEPTH);
  assign head_o             = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= cmd_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> status_o.not_empty)
    else $error("pop from empty command queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !status_o.full)
    else $error("push into full command queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |=> count_q == $past(count_q) + 1'b1)
    else $error("queue count lost a push");

endmodule

// ----- rtl/core/psmv_back.sv -----
module psmv_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    transpose_i,
  input  psmv_pkg::cmd_t          head_i,
  input  psmv_pkg::queue_status_t q_status_i,
  output logic                    pop_o,
  psmv_out_if.source              out_o
);

  // vector memory, sat mark kept in the same word as the value
  psmv_pkg::word_t                mem_q [psmv_pkg::VECTOR_DEPTH];
  psmv_pkg::word_t                rdata_q;

  logic                           ex_valid_q, ex_valid_d;
  psmv_pkg::cmd_t                 ex_cmd_q;

  logic signed [psmv_pkg::SUM_BITS-1:0] row_sum_q, row_sum_d;
  logic                           row_sat_q, row_sat_d;
  logic [psmv_pkg::ROW_BITS-1:0]  row_cnt_q, row_cnt_d;
  psmv_pkg::word_t                scale_q, scale_d;

  logic                           out_valid_q, out_valid_d;
  logic                           out_kind_q, out_kind_d;
  logic [psmv_pkg::ROW_BITS-1:0]  out_row_q, out_row_d;
  psmv_pkg::word_t                out_word_q, out_word_d;

  logic                           needs_out;
  logic                           ex_fire;
  logic                           mem_we;
  psmv_pkg::word_t                mem_wdata;
  psmv_pkg::word_t                acc;
  psmv_pkg::word_t                rd_word;

  assign needs_out = (ex_cmd_q.op == psmv_pkg::OP_READ) ||
                     (ex_cmd_q.op == psmv_pkg::OP_END_ROW && !transpose_i);
  assign ex_fire   = ex_valid_q && (!needs_out || !out_valid_q || out_o.ready);
  assign pop_o     = q_status_i.not_empty && (!ex_valid_q || ex_fire);
  assign rd_word   = ex_cmd_q.in_range ? rdata_q : '0;

  always_comb begin
    ex_valid_d  = pop_o ? 1'b1 : (ex_fire ? 1'b0 : ex_valid_q);
    row_sum_d   = row_sum_q;
    row_sat_d   = row_sat_q;
    row_cnt_d   = row_cnt_q;
    scale_d     = scale_q;
    mem_we      = 1'b0;
    mem_wdata   = ex_cmd_q.data;
    acc         = psmv_pkg::sat_add(row_sum_q, rd_word.value);
    out_valid_d = out_valid_q && !out_o.ready;
    out_kind_d  = out_kind_q;
    out_row_d   = out_row_q;
    out_word_d  = out_word_q;
    case (ex_cmd_q.op)
      psmv_pkg::OP_WRITE: begin
        mem_we = ex_fire && ex_cmd_q.in_range;
      end
      psmv_pkg::OP_SCALE: begin
        if (ex_fire) begin
          scale_d = ex_cmd_q.data;
        end
      end
      psmv_pkg::OP_COLUMN: begin
        if (!transpose_i) begin
          if (ex_fire) begin
            row_sum_d = acc.value;
            row_sat_d = row_sat_q || acc.sat;
          end
        end else begin
          acc           = psmv_pkg::sat_add(rdata_q.value, scale_q.value);
          mem_we        = ex_fire && ex_cmd_q.in_range;
          mem_wdata.value = acc.value;
          mem_wdata.sat = rdata_q.sat || acc.sat || scale_q.sat;
        end
      end
      psmv_pkg::OP_END_ROW: begin
        if (ex_fire) begin
          row_sum_d = '0;
          row_sat_d = 1'b0;
          row_cnt_d = row_cnt_q + 1'b1;
          if (!transpose_i) begin
            out_valid_d = 1'b1;
            out_kind_d  = psmv_pkg::KIND_ROW_SUM;
            out_row_d   = row_cnt_q;
            out_word_d  = '{sat: row_sat_q, value: row_sum_q};
          end
        end
      end
      psmv_pkg::OP_READ: begin
        if (ex_fire) begin
          out_valid_d = 1'b1;
          out_kind_d  = psmv_pkg::KIND_READ;
          out_row_d   = ex_cmd_q.index;
          out_word_d  = rd_word;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_valid_q  <= 1'b0;
      row_sum_q   <= '0;
      row_sat_q   <= 1'b0;
      row_cnt_q   <= '0;
      scale_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      ex_valid_q  <= ex_valid_d;
      row_sum_q   <= row_sum_d;
      row_sat_q   <= row_sat_d;
      row_cnt_q   <= row_cnt_d;
      scale_q     <= scale_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ex_cmd_q <= head_i;
    end
    out_kind_q <= out_kind_d;
    out_row_q  <= out_row_d;
    out_word_q <= out_word_d;
  end

  // read with bypass of the write landing on the same edge
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[ex_cmd_q.addr] <= mem_wdata;
    end
    if (pop_o) begin
      if (mem_we && ex_cmd_q.addr == head_i.addr) begin
        rdata_q <= mem_wdata;
      end else begin
        rdata_q <= mem_q[head_i.addr];
      end
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.kind         = out_kind_q;
  assign out_o.row_number   = out_row_q;
  assign out_o.result_value = psmv_pkg::to_out(out_word_q.value);
  assign out_o.saturated    = out_word_q.sat;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ex_fire && ex_cmd_q.op == psmv_pkg::OP_END_ROW |=>
      row_cnt_q == $past(row_cnt_q) + 1'b1 && row_sum_q == '0 && !row_sat_q)
    else $error("end of row did not advance and clear the row state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ex_fire && !needs_out && (!out_valid_q || out_o.ready) |=> !out_valid_q)
    else $error("result raised by an item that gives none");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ex_valid_q && !ex_fire |=> ex_valid_q && $stable(ex_cmd_q))
    else $error("stalled execute stage lost its item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> ex_fire && ex_cmd_q.in_range)
    else $error("vector memory written outside an executing item");

endmodule

// ----- rtl/core/pattern_sparse_matrix_vector_product.sv -----
// path: command queue slot, then execute stage, then output register, where the result is valid
// throughput: one transaction per cycle when not stalled, set by the single memory port pair
//   (one read at issue, one write at execute, same-address write bypassed to the read)
// a stalled result holds only the execute stage; the 4-entry queue takes input until full
// reset: asynchronous active low; clears control, row state, scale and transpose mode
//   vector memory is not cleared and must be written by the host before use
module pattern_sparse_matrix_vector_product (
  input  logic       clk_i,
  input  logic       rst_ni,
  psmv_cfg_if.sink   cfg_i,
  psmv_in_if.sink    in_i,
  psmv_out_if.source out_o
);

  // configuration register, always ready
  logic transpose_q;

  // front to queue
  logic                    push;
  psmv_pkg::cmd_t          push_cmd;

  // queue to back
  logic                    pop;
  psmv_pkg::cmd_t          head_cmd;
  psmv_pkg::queue_status_t q_status;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      transpose_q <= 1'b0;
    end else if (cfg_i.valid) begin
      transpose_q <= cfg_i.transpose_mode;
    end
  end

  // front: takes each input transaction, decodes the operation, clamps the value
  // into the sum range and drops unknown operation codes
  psmv_front u_front (
    .in_i       (in_i),
    .q_status_i (q_status),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  // short command queue so front and back stall independently
  psmv_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .cmd_i      (push_cmd),
    .pop_i      (pop),
    .head_o     (head_cmd),
    .status_o   (q_status)
  );

  // back: reads the vector memory on pop, then accumulates the row sum or
  // does the read-modify-write of the transposed update, and drives results
  psmv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .transpose_i (transpose_q),
    .head_i      (head_cmd),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_o       (out_o)
  );

endmodule

// ----- tb/sv/pattern_sparse_matrix_vector_product_tb.sv -----
`timescale 1ns / 100ps

module pattern_sparse_matrix_vector_product_tb;
  import psmv_pkg::*;

  // operation codes the block has no use for, sent as noise
  localparam logic [OP_BITS-1:0] OP_SPARE_5 = 3'd5;
  localparam logic [OP_BITS-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_BITS-1:0] OP_SPARE_7 = 3'd7;

  // saturation bounds of the signed sum, Q32.16
  localparam longint SUM_HI = (longint'(1) <<< (SUM_BITS - 1)) - 1;
  localparam longint SUM_LO = -SUM_HI - 1;

  // full-scale adds that build one large entry; a forward row of one more
  // column over that entry passes the top of the sum range
  localparam int RAMP_ADDS = 1 << ((SUM_BITS - VALUE_BITS + 1) / 2);

  // cycles allowed for the command queue and pipe to empty when no result marks it
  localparam int SETTLE_CYCLES = QUEUE_DEPTH + 8;

  typedef struct packed {
    kind_e                      kind;
    logic [ROW_BITS-1:0]        row;
    logic signed [OUT_BITS-1:0] value;
    logic                       sat;
  } result_t;

  // one line of the directed stimulus: either a mode change or a transaction
  typedef struct packed {
    bit                      set_mode;
    bit                      typed;
    logic [OP_BITS-1:0]      op;
    logic [ROW_BITS-1:0]     idx;
    logic [VALUE_BITS-1:0]   val;
    result_t                 want;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  psmv_cfg_if cfg_if ();
  psmv_in_if  in_if ();
  psmv_out_if out_if ();

  pattern_sparse_matrix_vector_product u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // shadow of the block: vector memory, its saturation marks and the row state
  longint              shadow_vec [VECTOR_DEPTH];
  bit                  shadow_mark [VECTOR_DEPTH];
  longint              row_acc;
  bit                  row_hit;
  logic [ROW_BITS-1:0] row_cnt;
  longint              scale_q;
  bit                  transpose_q;

  // entries the host has written, the only ones that may be read or accumulated
  bit                  filled [VECTOR_DEPTH];
  int                  filled_list [$];

  // row sums and memory reads the block still owes us, oldest first
  result_t             sums_and_reads [$];

  int                  mismatches;
  bit                  steady;       // no idling on either side while set
  int                  stall_left;
  int                  random_items;
  int                  phase_target;
  int                  phase_idx;
  int                  cols;
  int                  pick;
  bit                  next_mode;
  stim_row_t           directed_rows [$];

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard stop in case the block hangs
  initial begin
    #10ms;
    $display("Regression FAIL");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // signed add that clamps into the sum range and flags the clamp
  function automatic longint add_clamped(input longint a, input longint b, output bit hit);
    longint s;
    s   = a + b;
    hit = 1'b0;
    if (s > SUM_HI) begin
      s   = SUM_HI;
      hit = 1'b1;
    end else if (s < SUM_LO) begin
      s   = SUM_LO;
      hit = 1'b1;
    end
    return s;
  endfunction

  // applies one accepted transaction to the shadow, returns 1 when it yields a result
  function automatic bit compute_spmv_item(input logic [OP_BITS-1:0] op,
                                           input logic [ROW_BITS-1:0] idx,
                                           input logic signed [VALUE_BITS-1:0] val,
                                           output result_t res);
    longint x;
    bit     hit;
    res = '0;
    x   = val;
    compute_spmv_item = 1'b0;
    case (op)
      OP_WRITE: begin
        shadow_vec[idx]  = add_clamped(x, 0, hit);
        shadow_mark[idx] = hit;
      end
      OP_SCALE: begin
        scale_q = x;
      end
      OP_COLUMN: begin
        // forward sums x at the column, transposed pushes the scale into y
        if (!transpose_q) begin
          row_acc = add_clamped(row_acc, shadow_vec[idx], hit);
          if (hit) row_hit = 1'b1;
        end else begin
          shadow_vec[idx] = add_clamped(shadow_vec[idx], scale_q, hit);
          if (hit) shadow_mark[idx] = 1'b1;
        end
      end
      OP_END_ROW: begin
        if (!transpose_q) begin
          res.kind  = KIND_ROW_SUM;
          res.row   = row_cnt;
          res.value = row_acc[OUT_BITS-1:0];
          res.sat   = row_hit;
          compute_spmv_item = 1'b1;
        end
        row_acc = 0;
        row_hit = 1'b0;
        row_cnt = row_cnt + 1'b1;
      end
      OP_READ: begin
        x         = shadow_vec[idx];
        res.kind  = KIND_READ;
        res.row   = idx;
        res.value = x[OUT_BITS-1:0];
        res.sat   = shadow_mark[idx];
        compute_spmv_item = 1'b1;
      end
      default: ;
    endcase
  endfunction

  // back to back while steady, else mostly back to back, sometimes a short gap, rarely a long pause
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [VALUE_BITS-1:0] pick_q16();
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return $urandom_range(0, 32'h000f_ffff) - 32'h0008_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [ROW_BITS-1:0] pick_filled();
    return ROW_BITS'(filled_list[$urandom_range(0, filled_list.size() - 1)]);
  endfunction

  function automatic logic [ROW_BITS-1:0] pick_any();
    return ROW_BITS'($urandom);
  endfunction

  // one input transaction; the shadow is updated on the accepting edge
  task automatic drive_item(input logic [OP_BITS-1:0] op, input logic [ROW_BITS-1:0] idx,
                            input logic [VALUE_BITS-1:0] val,
                            input bit typed, input result_t want);
    result_t got;
    int      gap;
    in_if.valid     <= 1'b1;
    in_if.operation <= op;
    in_if.index     <= idx;
    in_if.value     <= val;
    do @(posedge clk_i); while (!in_if.ready);
    if (op == OP_WRITE && !filled[idx]) begin
      filled[idx] = 1'b1;
      filled_list.push_back(idx);
    end
    if (compute_spmv_item(op, idx, val, got)) sums_and_reads.push_back(typed ? want : got);
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send(input logic [OP_BITS-1:0] op, input logic [ROW_BITS-1:0] idx,
                      input logic [VALUE_BITS-1:0] val);
    drive_item(op, idx, val, 1'b0, '0);
  endtask

  // wait for every owed result, then let the queue empty of silent commands
  task automatic drain_block();
    in_if.valid <= 1'b0;
    while (sums_and_reads.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_mode(input bit mode);
    cfg_if.valid          <= 1'b1;
    cfg_if.transpose_mode <= mode;
    do @(posedge clk_i); while (!cfg_if.ready);
    transpose_q = mode;
    cfg_if.valid <= 1'b0;
  endtask

  // output side: ready most of the time with random stalls
  initial begin
    out_if.ready <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if ($urandom_range(0, 5) == 0) stall_left = pick_gap();
      end
    end
  end

  // result checker: each result transaction against the oldest expectation
  always @(posedge clk_i) begin
    result_t exp_res;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (sums_and_reads.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d row %0d value %h",
                                  out_if.kind, out_if.row_number, out_if.result_value));
      end else begin
        exp_res = sums_and_reads.pop_front();
        if (out_if.kind !== exp_res.kind)
          report_mismatch($sformatf("kind %0d, wanted %0d", out_if.kind, exp_res.kind));
        if (out_if.row_number !== exp_res.row)
          report_mismatch($sformatf("row_number %0d, wanted %0d",
                                    out_if.row_number, exp_res.row));
        if (out_if.result_value !== exp_res.value)
          report_mismatch($sformatf("row %0d result_value %h, wanted %h",
                                    exp_res.row, out_if.result_value, exp_res.value));
        if (out_if.saturated !== exp_res.sat)
          report_mismatch($sformatf("row %0d saturated %0d, wanted %0d",
                                    exp_res.row, out_if.saturated, exp_res.sat));
      end
    end
  end

  initial begin
    // directed rows: mode, op, index, value, and a typed result where it is obvious
    // forward mode out of reset
    directed_rows.push_back('{1'b0, 1'b1, OP_END_ROW, 10'h000, 32'h0,
                              '{KIND_ROW_SUM, 10'd0, 48'sh0, 1'b0}});
    directed_rows.push_back('{1'b0, 1'b0, OP_WRITE, 10'h000, 32'h7fff_ffff, '0});
    directed_rows.push_back('{1'b0, 1'b0, OP_WRITE, 10'h3ff, 32'h8000_0000, '0});
    directed_rows.push_back('{1'b0, 1'b1, OP_READ, 10'h000, 32'h0,
                              '{KIND_READ, 10'h000, 48'sh7fff_ffff, 1'b0}});
    directed_rows.push_back('{1'b0, 1'b1, OP_READ, 10'h3ff, 32'hffff_ffff,
                              '{KIND_READ, 10'h3ff, -48'sh8000_0000, 1'b0}});
    directed_rows.push_back('{1'b0, 1'b0, OP_WRITE, 10'h155, 32'h1234_5678, '0});
    directed_rows.push_back('{1'b0, 1'b0, OP_WRITE, 10'h2aa, 32'hffff_0000, '0});
    // scale has no effect on a forward row
    directed_rows.push_back('{1'b0, 1'b0, OP_SCALE, 10'h000, 32'h0001_0000, '0});
    directed_rows.push_back('{1'b0, 1'b0, OP_COLUMN, 10'h000, 32'h0, '0});
    directed_rows.push_back('{1'b0, 1'b0, OP_COLUMN, 10'h3ff, 32'h0, '0});
    directed_rows.push_back('{1'b0, 1'b0, OP_COLUMN, 10'h155, 32'h0, '0});
    directed_rows.push_back('{1'b0, 1'b0, OP_END_ROW, 10'h000, 32'h0, '0});
    // unused codes are dropped without a result
    directed_rows.push_back('{1'b0, 1'b0, OP_SPARE_5, 10'h3ff, 32'hffff_ffff, '0});
    directed_rows.push_back('{1'b0, 1'b0, OP_SPARE_6, 10'h2aa, 32'h5555_5555, '0});
    directed_rows.push_back('{1'b0, 1'b0, OP_SPARE_7, 10'h155, 32'haaaa_aaaa, '0});
    // a row with no columns still gets its sum of zero
    directed_rows.push_back('{1'b0, 1'b0, OP_END_ROW, 10'h000, 32'h0, '0});
    // transposed: y[col] += scale, end of row is silent, read back afterward
    directed_rows.push_back('{1'b1, 1'b0, OP_WRITE, 10'h000, 32'h1, '0});
    directed_rows.push_back('{1'b0, 1'b0, OP_SCALE, 10'h000, 32'hfffe_0000, '0});
    directed_rows.push_back('{1'b0, 1'b0, OP_COLUMN, 10'h2aa, 32'h0, '0});
    directed_rows.push_back('{1'b0, 1'b0, OP_COLUMN, 10'h2aa, 32'h0, '0});
    directed_rows.push_back('{1'b0, 1'b0, OP_END_ROW, 10'h000, 32'h0, '0});
    directed_rows.push_back('{1'b0, 1'b0, OP_READ, 10'h2aa, 32'h0, '0});
    directed_rows.push_back('{1'b0, 1'b0, OP_COLUMN, 10'h155, 32'h0, '0});
    directed_rows.push_back('{1'b0, 1'b0, OP_READ, 10'h155, 32'h0, '0});
    directed_rows.push_back('{1'b1, 1'b0, OP_WRITE, 10'h000, 32'h0, '0});

    // every input known from time zero, reset asserted first and then released
    mismatches = 0;
    steady     = 1'b0;
    row_acc    = 0;
    row_hit    = 1'b0;
    row_cnt    = '0;
    scale_q    = 0;
    transpose_q = 1'b0;
    rst_ni                <= 1'b0;
    in_if.valid           <= 1'b0;
    in_if.operation       <= OP_WRITE;
    in_if.index           <= '0;
    in_if.value           <= '0;
    cfg_if.valid          <= 1'b0;
    cfg_if.transpose_mode <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    foreach (directed_rows[i]) begin
      if (directed_rows[i].set_mode) begin
        drain_block();
        write_mode(directed_rows[i].val[0]);
      end else begin
        drive_item(directed_rows[i].op, directed_rows[i].idx, directed_rows[i].val,
                   directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // saturation ramp: a transposed run of full-scale steps builds one large entry,
    // no idling so it goes by quickly
    drain_block();
    steady = 1'b1;
    write_mode(1'b1);
    send(OP_WRITE, 10'h001, 32'h0);
    send(OP_SCALE, 10'h000, 32'h7fff_ffff);
    repeat (RAMP_ADDS) send(OP_COLUMN, 10'h001, 32'h0);
    send(OP_END_ROW, 10'h000, 32'h0);
    send(OP_READ, 10'h001, 32'h0);
    // a forward row over the large entry clips at the top,
    // and the row flag stays set once hit
    drain_block();
    write_mode(1'b0);
    repeat (RAMP_ADDS + 1) send(OP_COLUMN, 10'h001, 32'h0);
    send(OP_COLUMN, 10'h3ff, 32'h0);
    send(OP_END_ROW, 10'h000, 32'h0);
    steady = 1'b0;

    // random part in phases, the mode flipping between phases
    random_items = 0;
    phase_idx    = 0;
    next_mode    = 1'b1;
    while (random_items < 200) begin
      drain_block();
      write_mode(next_mode);
      next_mode    = ~next_mode;
      steady       = ($urandom_range(0, 3) == 0);
      phase_target = random_items + $urandom_range(40, 90);
      while (random_items < phase_target) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          // well-formed row: optional scale, some columns, end
          if ($urandom_range(0, 3) != 0) begin
            send(OP_SCALE, pick_any(), pick_q16());
            random_items++;
          end
          cols = $urandom_range(0, 6);
          repeat (cols) send(OP_COLUMN, pick_filled(), $urandom);
          send(OP_END_ROW, pick_any(), $urandom);
          random_items += cols + 1;
        end else if (pick < 70) begin
          send(OP_WRITE, pick_any(), pick_q16());
          random_items++;
        end else if (pick < 85) begin
          send(OP_READ, pick_filled(), $urandom);
          random_items++;
        end else if (pick < 92) begin
          // stray column or scale outside a row shape
          if ($urandom_range(0, 1) != 0) send(OP_COLUMN, pick_filled(), $urandom);
          else send(OP_SCALE, pick_any(), pick_q16());
          random_items++;
        end else begin
          case ($urandom_range(0, 2))
            0:       send(OP_SPARE_5, pick_any(), $urandom);
            1:       send(OP_SPARE_6, pick_any(), $urandom);
            default: send(OP_SPARE_7, pick_any(), $urandom);
          endcase
        end
      end
      phase_idx++;
    end

    // wind down: all owed results, then a further wait for anything stray
    in_if.valid <= 1'b0;
    steady = 1'b0;
    for (int w = 0; w < 50000 && sums_and_reads.size() != 0; w++) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sums_and_reads.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", sums_and_reads.size()));

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/psmv_pkg.sv
rtl/core/psmv_in_if.sv
rtl/core/psmv_out_if.sv
rtl/core/psmv_cfg_if.sv
rtl/core/psmv_front.sv
rtl/core/psmv_queue.sv
rtl/core/psmv_back.sv
rtl/core/pattern_sparse_matrix_vector_product.sv
tb/sv/pattern_sparse_matrix_vector_product_tb.sv
